FILE: rtl/ubds_pkg.sv
// Shared widths and constants for the UART baud divisor search core.
// No dependencies; imported by the search core and the testbench.
package ubds_pkg;

	localparam int CLK_W  = 30;
	localparam int BAUD_W = 24;
	localparam int GEN_W  = 28;
	localparam int DIV_W  = 8;
	localparam int ERR_W  = 30;
	localparam int MUL_W  = DIV_W + 1;
	localparam int PROD_W = BAUD_W + MUL_W;
	localparam int M_W    = GEN_W + MUL_W;

	localparam logic [CLK_W-1:0] CLOCK_RESET = CLK_W'(100000000);

	typedef struct packed {
		logic               first;
		logic               last;
		logic [DIV_W-1:0]   div;
		logic [BAUD_W-1:0]  baud;
	} ubds_cand_t;

	typedef struct packed {
		logic               first;
		logic               last;
		logic               skip;
		logic [DIV_W-1:0]   div;
		logic [BAUD_W-1:0]  baud;
		logic [GEN_W-1:0]   gen;
	} ubds_eval_t;

endpackage

FILE: rtl/ubds_div_pipe.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Carries a side payload alongside the operands. Depends on nothing.
module ubds_div_pipe #(
	parameter int NW = 30,
	parameter int DW = 33,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_vld,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [SW-1:0] side,
	output logic          out_vld,
	output logic [NW-1:0] quo,
	output logic [SW-1:0] out_side
);

	logic [NW:0]   vld_s;
	logic [NW-1:0] num_s  [0:NW];
	logic [DW-1:0] rem_s  [0:NW];
	logic [NW-1:0] quo_s  [0:NW];
	logic [DW-1:0] den_s  [0:NW];
	logic [SW-1:0] side_s [0:NW];

	assign vld_s[0]  = in_vld;
	assign num_s[0]  = num;
	assign rem_s[0]  = '0;
	assign quo_s[0]  = '0;
	assign den_s[0]  = den;
	assign side_s[0] = side;

	for (genvar i = 0; i < NW; i++) begin : g_stage
		logic [DW:0] trial;
		logic        ge;
		logic [DW:0] diff;

		assign trial = {rem_s[i], num_s[i][NW-1]};
		assign ge    = trial >= {1'b0, den_s[i]};
		assign diff  = trial - {1'b0, den_s[i]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				num_s[i+1]  <= {num_s[i][NW-2:0], 1'b0};
				rem_s[i+1]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
				quo_s[i+1]  <= {quo_s[i][NW-2:0], ge};
				den_s[i+1]  <= den_s[i];
				side_s[i+1] <= side_s[i];
			end
		end
	end

	assign out_vld  = vld_s[NW];
	assign quo      = quo_s[NW];
	assign out_side = side_s[NW];

endmodule

FILE: rtl/uart_baud_divisor_search_core.sv
// UART baud divisor search: one request yields one best divisor/generator pair.
// Each request issues one candidate divisor per cycle unless the output stalls, for
// every divisor from MIN_DIVISOR to DIVISOR_END - 1; its result appears once its last
// candidate has passed stage 1, two 30-stage dividers and three more stages.
// Reset clears all valid bits and the issuer, and loads the clock register
// with 100000000.
module uart_baud_divisor_search_core
	import ubds_pkg::*;
#(
	parameter int MIN_DIVISOR = 4,
	parameter int DIVISOR_END = 255
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CLK_W-1:0]  cfg_wdata,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [BAUD_W-1:0] req_baud,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [GEN_W-1:0]  generator_count,
	output logic [DIV_W-1:0]  baud_divisor,
	output logic [ERR_W-1:0]  baud_error,
	output logic              found
);

	localparam logic [DIV_W-1:0] D_FIRST = DIV_W'(MIN_DIVISOR);
	localparam logic [DIV_W-1:0] D_LAST  = DIV_W'(DIVISOR_END - 1);

	logic [CLK_W-1:0]  clk_hz_q;
	logic              busy_q;
	logic [DIV_W-1:0]  div_q;
	logic [BAUD_W-1:0] baud_q;
	logic              adv;
	logic              accept;

	// The whole pipeline freezes only while a finished result waits downstream.
	assign adv      = !(out_valid && out_stall);
	assign in_stall = busy_q || !adv;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clk_hz_q <= CLOCK_RESET;
		end else if (cfg_we) begin
			clk_hz_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (accept) begin
			busy_q <= 1'b1;
		end else if (adv && busy_q && div_q == D_LAST) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			div_q  <= D_FIRST;
			baud_q <= req_baud;
		end else if (adv && busy_q) begin
			div_q <= div_q + 1'b1;
		end
	end

	// Stage 1: product of the requested rate and divisor plus one.
	logic              vld_s1;
	ubds_cand_t        cand_s1;
	logic [PROD_W-1:0] prod_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cand_s1.first <= div_q == D_FIRST;
			cand_s1.last  <= div_q == D_LAST;
			cand_s1.div   <= div_q;
			cand_s1.baud  <= baud_q;
			prod_s1       <= PROD_W'(baud_q) * PROD_W'({1'b0, div_q} + MUL_W'(1));
		end
	end

	logic             d1_vld;
	logic [CLK_W-1:0] d1_quo;
	ubds_cand_t       d1_cand;

	ubds_div_pipe #(
		.NW(CLK_W),
		.DW(PROD_W),
		.SW($bits(ubds_cand_t))
	) u_gen_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.in_vld  (vld_s1),
		.num     (clk_hz_q),
		.den     (prod_s1),
		.side    (cand_s1),
		.out_vld (d1_vld),
		.quo     (d1_quo),
		.out_side(d1_cand)
	);

	// Stage 2: generator count times divisor plus one, and the skip flag.
	logic             vld_s2;
	ubds_eval_t       eval_s2;
	logic [M_W-1:0]   m_s2;
	logic [GEN_W-1:0] gen_cut;

	// The generator count never exceeds 28 bits once the rate is nonzero.
	assign gen_cut = d1_quo[GEN_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= d1_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			eval_s2.first <= d1_cand.first;
			eval_s2.last  <= d1_cand.last;
			eval_s2.skip  <= (d1_cand.baud == '0) || (d1_quo == '0);
			eval_s2.div   <= d1_cand.div;
			eval_s2.baud  <= d1_cand.baud;
			eval_s2.gen   <= gen_cut;
			m_s2          <= M_W'(gen_cut) * M_W'({1'b0, d1_cand.div} + MUL_W'(1));
		end
	end

	logic             d2_vld;
	logic [CLK_W-1:0] d2_quo;
	ubds_eval_t       d2_eval;

	ubds_div_pipe #(
		.NW(CLK_W),
		.DW(M_W),
		.SW($bits(ubds_eval_t))
	) u_calc_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.in_vld  (vld_s2),
		.num     (clk_hz_q),
		.den     (m_s2),
		.side    (eval_s2),
		.out_vld (d2_vld),
		.quo     (d2_quo),
		.out_side(d2_eval)
	);

	// Stage 3: absolute error of the achieved rate.
	logic             vld_s3;
	ubds_eval_t       eval_s3;
	logic [ERR_W-1:0] err_s3;
	logic [CLK_W-1:0] baud_ext;

	assign baud_ext = CLK_W'(d2_eval.baud);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= d2_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			eval_s3 <= d2_eval;
			err_s3  <= (baud_ext > d2_quo) ? ERR_W'(baud_ext - d2_quo)
			                               : ERR_W'(d2_quo - baud_ext);
		end
	end

	// Running best; the first candidate of a request starts from nothing found.
	logic             best_found_q;
	logic [GEN_W-1:0] best_gen_q;
	logic [DIV_W-1:0] best_div_q;
	logic [ERR_W-1:0] best_err_q;
	logic             cur_found;
	logic             upd;
	logic             nxt_found;
	logic [GEN_W-1:0] nxt_gen;
	logic [DIV_W-1:0] nxt_div;
	logic [ERR_W-1:0] nxt_err;

	always_comb begin
		cur_found = eval_s3.first ? 1'b0 : best_found_q;
		upd       = !eval_s3.skip && (!cur_found || err_s3 < best_err_q);
		nxt_found = cur_found || upd;
		nxt_gen   = upd ? eval_s3.gen : (cur_found ? best_gen_q : '0);
		nxt_div   = upd ? eval_s3.div : (cur_found ? best_div_q : '0);
		nxt_err   = upd ? err_s3 : (cur_found ? best_err_q : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_found_q <= 1'b0;
		end else if (adv && vld_s3) begin
			best_found_q <= nxt_found;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld_s3) begin
			best_gen_q <= nxt_gen;
			best_div_q <= nxt_div;
			best_err_q <= nxt_err;
		end
	end

	// Output register, loaded when the last candidate of a request is scored.
	logic load_out;

	assign load_out = adv && vld_s3 && eval_s3.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load_out) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			generator_count <= nxt_gen;
			baud_divisor    <= nxt_div;
			baud_error      <= nxt_err;
			found           <= nxt_found;
		end
	end

endmodule

FILE: tb/tb_top.sv
// Testbench for the UART baud divisor search core: drives baud rate requests,
// predicts the best divisor search result and checks every response.
// Depends on ubds_pkg and uart_baud_divisor_search_core.
`timescale 1ns / 100ps

module tb_top;
	import ubds_pkg::*;

	typedef struct packed {
		logic [GEN_W-1:0] gen;
		logic [DIV_W-1:0] div;
		logic [ERR_W-1:0] err;
		logic             fnd;
	} search_res_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [CLK_W-1:0]  cfg_wdata = '0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [BAUD_W-1:0] req_baud = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [GEN_W-1:0]  generator_count;
	logic [DIV_W-1:0]  baud_divisor;
	logic [ERR_W-1:0]  baud_error;
	logic              found;

	logic [BAUD_W-1:0] pending_bauds[$];
	search_res_t       expected_results[$];
	logic [CLK_W-1:0]  clock_hz;
	logic              in_taken = 1'b0;
	int                mismatches = 0;
	int                in_gap = 0;
	int                out_gap = 0;

	uart_baud_divisor_search_core dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .req_baud(req_baud),
		.out_valid(out_valid), .out_stall(out_stall),
		.generator_count(generator_count), .baud_divisor(baud_divisor),
		.baud_error(baud_error), .found(found)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic search_res_t best_divisor(input logic [BAUD_W-1:0] b,
			input logic [CLK_W-1:0] hz);
		search_res_t r;
		longint unsigned prod, g, c, e;
		r = '0;
		for (int d = 4; d < 255; d++) begin
			prod = longint'(b) * (d + 1);
			if (prod == 0) continue;
			g = longint'(hz) / prod;
			if (g == 0) continue;
			c = longint'(hz) / (g * (d + 1));
			e = (b > c) ? (b - c) : (c - b);
			if (!r.fnd || e < r.err) begin
				r.fnd = 1'b1;
				r.gen = g[GEN_W-1:0];
				r.div = d[DIV_W-1:0];
				r.err = e[ERR_W-1:0];
			end
		end
		return r;
	endfunction

	// A request is taken at the rising edge; its prediction is made there too.
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			expected_results.push_back(best_divisor(req_baud, clock_hz));
			in_taken = 1'b1;
		end
	end

	// Driver: presents one request at a time after a random gap.
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_taken) begin
				in_taken = 1'b0;
				in_gap = $urandom_range(0, 19);
				void'(pending_bauds.pop_front());
				if (in_gap == 0 && pending_bauds.size() > 0) begin
					req_baud <= pending_bauds[0];
				end else begin
					in_valid <= 1'b0;
				end
			end else if (!in_valid) begin
				if (in_gap > 0) begin
					in_gap = in_gap - 1;
				end else if (pending_bauds.size() > 0) begin
					req_baud <= pending_bauds[0];
					in_valid <= 1'b1;
				end
			end
		end
	end

	// The stall decision is made at the falling edge, the response taken at the rising edge.
	always @(negedge clk) begin
		if (out_gap > 0) begin
			out_gap = out_gap - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		search_res_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			out_gap = $urandom_range(0, 19);
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected response gen=%0d div=%0d",
						generator_count, baud_divisor);
			end else begin
				exp_r = expected_results.pop_front();
				if (exp_r.gen !== generator_count || exp_r.div !== baud_divisor ||
						exp_r.err !== baud_error || exp_r.fnd !== found) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp gen=%0d div=%0d err=%0d fnd=%0d got %0d %0d %0d %0d",
							exp_r.gen, exp_r.div, exp_r.err, exp_r.fnd,
							generator_count, baud_divisor, baud_error, found);
				end
			end
		end
	end

	task automatic write_clock(input logic [CLK_W-1:0] hz);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= hz;
		clock_hz = hz;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain;
		while (pending_bauds.size() > 0 || in_valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	function automatic logic [BAUD_W-1:0] random_baud(input logic [CLK_W-1:0] hz);
		int unsigned k;
		k = $urandom_range(0, 9);
		if (k == 0) return BAUD_W'($urandom());
		if (k == 1) return BAUD_W'($urandom_range(0, 20));
		// Mostly rates that the clock can actually reach with some divisor.
		return BAUD_W'($urandom_range(1, (hz / 5 > 16777215) ? 16777215 : (hz / 5 + 1)));
	endfunction

	initial begin
		logic [CLK_W-1:0] clocks[6];
		clock_hz = CLOCK_RESET;
		clocks = '{30'd1000000, 30'h3FFFFFFF, 30'd0, 30'd100, 30'd48000000, 30'd1000000000};
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		// Directed requests at the reset clock value.
		pending_bauds = '{24'd0, 24'd1, 24'hFFFFFF, 24'd9600, 24'd115200,
			24'd10000000, 24'd4000000, 24'd9999999, 24'hAAAAAA, 24'h555555};
		drain();
		for (int p = 0; p < 6; p++) begin
			write_clock(clocks[p]);
			pending_bauds.push_back(24'd0);
			pending_bauds.push_back(24'd1);
			pending_bauds.push_back(24'hFFFFFF);
			pending_bauds.push_back(24'd9600);
			for (int i = 0; i < 60; i++) pending_bauds.push_back(random_baud(clock_hz));
			drain();
		end
		write_clock(CLK_W'($urandom_range(1000000, 1000000000)));
		for (int i = 0; i < 200; i++) pending_bauds.push_back(random_baud(clock_hz));
		drain();
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin
		#(8 * 1200000);
		$display("== FAIL ==");
		$finish;
	end

endmodule
